// ----- src/scp_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the sprite camera projection block.
// Register index codes, reset values and field widths; no dependencies.
package scp_pkg;

    // Default fixed-point formats
    localparam int POS_FRAC_BITS_DEF = 8;
    localparam int DIR_FRAC_BITS_DEF = 14;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_POS_X     = 3'd0,
        CFG_CAM_POS_Y     = 3'd1,
        CFG_VIEW_DIR_X    = 3'd2,
        CFG_VIEW_DIR_Y    = 3'd3,
        CFG_CAM_PLANE_X   = 3'd4,
        CFG_CAM_PLANE_Y   = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } cfg_idx_t;

    // Register reset values
    localparam logic [15:0] RST_CAM_POS_X     = 16'd0;
    localparam logic [15:0] RST_CAM_POS_Y     = 16'd0;
    localparam logic [15:0] RST_VIEW_DIR_X    = 16'd16384;
    localparam logic [15:0] RST_VIEW_DIR_Y    = 16'd0;
    localparam logic [15:0] RST_CAM_PLANE_X   = 16'd0;
    localparam logic [15:0] RST_CAM_PLANE_Y   = 16'd10813;
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;

    // Field widths
    localparam int DEPTH_W  = 24;
    localparam int COL_W    = 16;
    localparam int SIZE_W   = 15;
    localparam int ROW_W    = 12;
    localparam int SCREEN_W = 13;

endpackage

// ----- src/sprite_camera_projection.sv -----
`timescale 1ns / 1ps
// Top level of the sprite camera projection block: a deep pipeline with
// two banks of restoring divider stages. Depends on scp_pkg.
//
// Usage:
//   Input channel s_valid/s_ready carries one sprite map position
//   (s_obj_x, s_obj_y). Result channel m_valid/m_ready carries the
//   projected sprite: distance, camera-space position, flags, center
//   column, size and clamped draw bounds.
//   Camera registers are written through cfg_we/cfg_idx/cfg_wdata, one
//   register per cycle; the user must write them only while no
//   transaction is in flight, as the block does not enforce this.
// Throughput: one transaction enters per cycle while s_ready is high.
//   Most stages belong to the two divider banks: 25 stages for camera x
//   and depth (overflow check plus 24 quotient bits) and 17 stages for
//   center column and size (overflow check plus 16 bits).
// Reset and stall:
//   Synchronous active-low reset clears all stage valid bits and loads the
//   register defaults. Each stage holds while its successor is full and
//   stalled, so empty stages keep filling while m_ready is low; s_ready
//   drops only once every stage holds a transaction.
module sprite_camera_projection #(
    parameter int POS_FRAC_BITS = scp_pkg::POS_FRAC_BITS_DEF,
    parameter int DIR_FRAC_BITS = scp_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [scp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // sprite input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [15:0]                        s_obj_x,
    input  logic [15:0]                        s_obj_y,
    // projection result
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [31:0]                        m_dist_sq,
    output logic signed [scp_pkg::DEPTH_W-1:0] m_cam_x,
    output logic signed [scp_pkg::DEPTH_W-1:0] m_cam_depth,
    output logic                               m_in_front,
    output logic                               m_depth_zero,
    output logic signed [scp_pkg::COL_W-1:0]   m_center_col,
    output logic [scp_pkg::SIZE_W-1:0]         m_sprite_size,
    output logic [scp_pkg::ROW_W-1:0]          m_top_row,
    output logic [scp_pkg::ROW_W-1:0]          m_bottom_row,
    output logic [scp_pkg::SIZE_W-1:0]         m_left_col,
    output logic signed [scp_pkg::COL_W-1:0]   m_right_col
);
    import scp_pkg::*;

    // Divider A: camera x and depth
    localparam int QA_W = DEPTH_W;
    localparam int NA_W = 35 + DIR_FRAC_BITS;
    localparam int DA_W = 33;
    localparam int CA_W = ((NA_W > DA_W + QA_W) ? NA_W : DA_W + QA_W) + 1;
    // Divider B: center column and size
    localparam int QB_W = COL_W;
    localparam int NB_W = 38;
    localparam int NS_W = SCREEN_W + POS_FRAC_BITS;
    localparam int DB_W = DEPTH_W;
    localparam int CB_W = ((NB_W > DB_W + QB_W) ? NB_W : DB_W + QB_W) + 1;

    // Stage numbering
    localparam int ST_IN   = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_ABS  = 4;
    localparam int ST_DA0  = 5;
    localparam int ST_TXY  = ST_DA0 + QA_W + 1;
    localparam int ST_CMUL = ST_TXY + 1;
    localparam int ST_CABS = ST_CMUL + 1;
    localparam int ST_DB0  = ST_CABS + 1;
    localparam int ST_CS   = ST_DB0 + QB_W + 1;
    localparam int ST_OUT  = ST_CS + 1;

    localparam logic signed [17:0] HALF_CELL = 18'(1 << (POS_FRAC_BITS - 1));
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic signed [COL_W-1:0]   COL_MAX   = {1'b0, {(COL_W-1){1'b1}}};
    localparam logic signed [COL_W-1:0]   COL_MIN   = {1'b1, {(COL_W-1){1'b0}}};
    localparam logic [SIZE_W-1:0]         SIZE_MAX  = '1;
    localparam logic [ROW_W-1:0]          ROW_MAX   = '1;

    // Saturate a signed quotient from its magnitude
    function automatic logic signed [DEPTH_W-1:0] sat_depth(input logic neg,
                                                            input logic ovf,
                                                            input logic [QA_W-1:0] q);
        logic signed [DEPTH_W-1:0] res;
        if (ovf) begin
            res = neg ? DEPTH_MIN : DEPTH_MAX;
        end else if (!neg) begin
            res = q[QA_W-1] ? DEPTH_MAX : $signed(q);
        end else begin
            res = (q > {1'b1, {(QA_W-1){1'b0}}}) ? DEPTH_MIN : -$signed(q);
        end
        return res;
    endfunction

    function automatic logic signed [COL_W-1:0] sat_col(input logic neg,
                                                        input logic ovf,
                                                        input logic [QB_W-1:0] q);
        logic signed [COL_W-1:0] res;
        if (ovf) begin
            res = neg ? COL_MIN : COL_MAX;
        end else if (!neg) begin
            res = q[QB_W-1] ? COL_MAX : $signed(q);
        end else begin
            res = (q > {1'b1, {(QB_W-1){1'b0}}}) ? COL_MIN : -$signed(q);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]         cam_pos_x_reg, cam_pos_y_reg;
    logic signed [15:0]  view_dir_x_reg, view_dir_y_reg;
    logic signed [15:0]  cam_plane_x_reg, cam_plane_y_reg;
    logic [SCREEN_W-1:0] screen_width_reg, screen_height_reg;
    cfg_idx_t            cfg_sel;

    assign cfg_sel = cfg_idx_t'(cfg_idx);

    // Decode and store register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_pos_x_reg     <= RST_CAM_POS_X;
            cam_pos_y_reg     <= RST_CAM_POS_Y;
            view_dir_x_reg    <= RST_VIEW_DIR_X;
            view_dir_y_reg    <= RST_VIEW_DIR_Y;
            cam_plane_x_reg   <= RST_CAM_PLANE_X;
            cam_plane_y_reg   <= RST_CAM_PLANE_Y;
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
        end else if (cfg_we) begin
            unique case (cfg_sel)
                CFG_CAM_POS_X:     cam_pos_x_reg     <= cfg_wdata;
                CFG_CAM_POS_Y:     cam_pos_y_reg     <= cfg_wdata;
                CFG_VIEW_DIR_X:    view_dir_x_reg    <= cfg_wdata;
                CFG_VIEW_DIR_Y:    view_dir_y_reg    <= cfg_wdata;
                CFG_CAM_PLANE_X:   cam_plane_x_reg   <= cfg_wdata;
                CFG_CAM_PLANE_Y:   cam_plane_y_reg   <= cfg_wdata;
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [ROW_W-1:0] half_w, half_h;
    assign half_w = screen_width_reg[SCREEN_W-1:1];
    assign half_h = screen_height_reg[SCREEN_W-1:1];

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    logic [ST_OUT:1]   v_reg;
    logic [ST_OUT+1:1] en;
    logic [ST_OUT-1:0] vchain;

    assign en[ST_OUT+1] = m_ready;
    genvar g;
    generate
        for (g = ST_OUT; g >= 1; g--) begin : g_en
            assign en[g] = !v_reg[g] || en[g+1];
        end
    endgenerate

    assign vchain  = {v_reg[ST_OUT-1:1], s_valid};
    assign s_ready = en[ST_IN];

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (en[ST_OUT:1] & vchain[ST_OUT-1:0]) | (~en[ST_OUT:1] & v_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from the player
    // ------------------------------------------------------------------
    logic signed [16:0] ex_reg, ey_reg, ex_next, ey_next;
    logic signed [17:0] sx_reg, sy_reg, sx_next, sy_next;

    always_comb begin
        ex_next = $signed({1'b0, cam_pos_x_reg}) - $signed({1'b0, s_obj_x});
        ey_next = $signed({1'b0, cam_pos_y_reg}) - $signed({1'b0, s_obj_y});
        sx_next = $signed({2'b0, s_obj_x}) - $signed({2'b0, cam_pos_x_reg}) + HALF_CELL;
        sy_next = $signed({2'b0, s_obj_y}) - $signed({2'b0, cam_pos_y_reg}) + HALF_CELL;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products
    // ------------------------------------------------------------------
    logic signed [33:0] exx_next, eyy_next;
    logic [31:0]        exx_reg, eyy_reg;
    logic signed [33:0] p_dysx_reg, p_dxsy_reg, p_plysx_reg, p_plxsy_reg;
    logic signed [31:0] p_plxdy_reg, p_dxply_reg;

    assign exx_next = ex_reg * ex_reg;
    assign eyy_next = ey_reg * ey_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            exx_reg     <= exx_next[31:0];
            eyy_reg     <= eyy_next[31:0];
            p_dysx_reg  <= view_dir_y_reg * sx_reg;
            p_dxsy_reg  <= view_dir_x_reg * sy_reg;
            p_plysx_reg <= cam_plane_y_reg * sx_reg;
            p_plxsy_reg <= cam_plane_x_reg * sy_reg;
            p_plxdy_reg <= cam_plane_x_reg * view_dir_y_reg;
            p_dxply_reg <= view_dir_x_reg * cam_plane_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: distance, cross terms and determinant
    // ------------------------------------------------------------------
    logic [32:0]        dist_next;
    logic [31:0]        s3_dist_reg;
    logic signed [34:0] nx_reg, ny_reg;
    logic signed [32:0] det_reg;

    assign dist_next = {1'b0, exx_reg} + {1'b0, eyy_reg};

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            s3_dist_reg <= dist_next[32] ? '1 : dist_next[31:0];
            nx_reg      <= 35'(p_dysx_reg) - 35'(p_dxsy_reg);
            ny_reg      <= 35'(p_plxsy_reg) - 35'(p_plysx_reg);
            det_reg     <= 33'(p_plxdy_reg) - 33'(p_dxply_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes and signs for divider A
    // ------------------------------------------------------------------
    logic [34:0]     nx_abs, ny_abs;
    logic [NA_W-1:0] s4_numx_reg, s4_numy_reg;
    logic [DA_W-1:0] s4_den_reg;
    logic            s4_negx_reg, s4_negy_reg, s4_dz_reg;
    logic [31:0]     s4_dist_reg;

    assign nx_abs = nx_reg[34] ? 35'(-nx_reg) : 35'(nx_reg);
    assign ny_abs = ny_reg[34] ? 35'(-ny_reg) : 35'(ny_reg);

    always_ff @(posedge aclk) begin
        if (en[ST_ABS]) begin
            s4_numx_reg <= NA_W'(nx_abs) << DIR_FRAC_BITS;
            s4_numy_reg <= NA_W'(ny_abs) << DIR_FRAC_BITS;
            s4_den_reg  <= det_reg[32] ? DA_W'(-det_reg) : DA_W'(det_reg);
            s4_negx_reg <= nx_reg[34] ^ det_reg[32];
            s4_negy_reg <= ny_reg[34] ^ det_reg[32];
            s4_dz_reg   <= (det_reg == '0);
            s4_dist_reg <= s3_dist_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider A: overflow check, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic [NA_W-1:0] da_remx_reg [0:QA_W];
    logic [NA_W-1:0] da_remy_reg [0:QA_W];
    logic [QA_W-1:0] da_qx_reg   [0:QA_W];
    logic [QA_W-1:0] da_qy_reg   [0:QA_W];
    logic [DA_W-1:0] da_den_reg  [0:QA_W];
    logic            da_ovfx_reg [0:QA_W];
    logic            da_ovfy_reg [0:QA_W];
    logic            da_negx_reg [0:QA_W];
    logic            da_negy_reg [0:QA_W];
    logic            da_dz_reg   [0:QA_W];
    logic [31:0]     da_dist_reg [0:QA_W];

    // Check that the quotient fits before the bit stages
    always_ff @(posedge aclk) begin
        if (en[ST_DA0]) begin
            da_remx_reg[0] <= s4_numx_reg;
            da_remy_reg[0] <= s4_numy_reg;
            da_qx_reg[0]   <= '0;
            da_qy_reg[0]   <= '0;
            da_den_reg[0]  <= s4_den_reg;
            da_ovfx_reg[0] <= CA_W'(s4_numx_reg) >= (CA_W'(s4_den_reg) << QA_W);
            da_ovfy_reg[0] <= CA_W'(s4_numy_reg) >= (CA_W'(s4_den_reg) << QA_W);
            da_negx_reg[0] <= s4_negx_reg;
            da_negy_reg[0] <= s4_negy_reg;
            da_dz_reg[0]   <= s4_dz_reg;
            da_dist_reg[0] <= s4_dist_reg;
        end
    end

    generate
        for (g = 1; g <= QA_W; g++) begin : g_div_a
            localparam int BIT = QA_W - g;
            logic [CA_W-1:0] dshift;
            logic            takex, takey;
            logic [NA_W-1:0] remx_next, remy_next;
            logic [QA_W-1:0] qx_next, qy_next;

            assign dshift = CA_W'(da_den_reg[g-1]) << BIT;
            assign takex  = CA_W'(da_remx_reg[g-1]) >= dshift;
            assign takey  = CA_W'(da_remy_reg[g-1]) >= dshift;

            always_comb begin
                remx_next      = takex ? da_remx_reg[g-1] - NA_W'(dshift) : da_remx_reg[g-1];
                remy_next      = takey ? da_remy_reg[g-1] - NA_W'(dshift) : da_remy_reg[g-1];
                qx_next        = da_qx_reg[g-1];
                qy_next        = da_qy_reg[g-1];
                qx_next[BIT]   = takex;
                qy_next[BIT]   = takey;
            end

            always_ff @(posedge aclk) begin
                if (en[ST_DA0+g]) begin
                    da_remx_reg[g] <= remx_next;
                    da_remy_reg[g] <= remy_next;
                    da_qx_reg[g]   <= qx_next;
                    da_qy_reg[g]   <= qy_next;
                    da_den_reg[g]  <= da_den_reg[g-1];
                    da_ovfx_reg[g] <= da_ovfx_reg[g-1];
                    da_ovfy_reg[g] <= da_ovfy_reg[g-1];
                    da_negx_reg[g] <= da_negx_reg[g-1];
                    da_negy_reg[g] <= da_negy_reg[g-1];
                    da_dz_reg[g]   <= da_dz_reg[g-1];
                    da_dist_reg[g] <= da_dist_reg[g-1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage: signed, saturated camera x and depth
    // ------------------------------------------------------------------
    logic signed [DEPTH_W-1:0] s30_tx_reg, s30_ty_reg;
    logic [31:0]               s30_dist_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_TXY]) begin
            s30_tx_reg   <= da_dz_reg[QA_W] ? '0 :
                            sat_depth(da_negx_reg[QA_W], da_ovfx_reg[QA_W], da_qx_reg[QA_W]);
            s30_ty_reg   <= da_dz_reg[QA_W] ? '0 :
                            sat_depth(da_negy_reg[QA_W], da_ovfy_reg[QA_W], da_qy_reg[QA_W]);
            s30_dist_reg <= da_dist_reg[QA_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage: center numerator half_w * (ty + tx)
    // ------------------------------------------------------------------
    logic signed [DEPTH_W:0]   sum_txy;
    logic signed [NB_W-1:0]    s31_prod_reg;
    logic signed [DEPTH_W-1:0] s31_tx_reg, s31_ty_reg;
    logic [31:0]               s31_dist_reg;

    assign sum_txy = (DEPTH_W+1)'(s30_ty_reg) + (DEPTH_W+1)'(s30_tx_reg);

    always_ff @(posedge aclk) begin
        if (en[ST_CMUL]) begin
            s31_prod_reg <= $signed({1'b0, half_w}) * sum_txy;
            s31_tx_reg   <= s30_tx_reg;
            s31_ty_reg   <= s30_ty_reg;
            s31_dist_reg <= s30_dist_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage: magnitudes for divider B
    // ------------------------------------------------------------------
    logic [NB_W-1:0]           s32_numc_reg;
    logic [NS_W-1:0]           s32_nums_reg;
    logic [DB_W-1:0]           s32_den_reg;
    logic                      s32_negc_reg;
    logic signed [DEPTH_W-1:0] s32_tx_reg, s32_ty_reg;
    logic [31:0]               s32_dist_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_CABS]) begin
            s32_numc_reg <= s31_prod_reg[NB_W-1] ? NB_W'(-s31_prod_reg) : NB_W'(s31_prod_reg);
            s32_nums_reg <= NS_W'(screen_height_reg) << POS_FRAC_BITS;
            s32_den_reg  <= s31_ty_reg[DEPTH_W-1] ? DB_W'(-s31_ty_reg) : DB_W'(s31_ty_reg);
            s32_negc_reg <= s31_prod_reg[NB_W-1] ^ s31_ty_reg[DEPTH_W-1];
            s32_tx_reg   <= s31_tx_reg;
            s32_ty_reg   <= s31_ty_reg;
            s32_dist_reg <= s31_dist_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider B: center column and sprite size side by side
    // ------------------------------------------------------------------
    logic [NB_W-1:0]           db_remc_reg [0:QB_W];
    logic [NS_W-1:0]           db_rems_reg [0:QB_W];
    logic [QB_W-1:0]           db_qc_reg   [0:QB_W];
    logic [QB_W-1:0]           db_qs_reg   [0:QB_W];
    logic [DB_W-1:0]           db_den_reg  [0:QB_W];
    logic                      db_ovfc_reg [0:QB_W];
    logic                      db_ovfs_reg [0:QB_W];
    logic                      db_negc_reg [0:QB_W];
    logic signed [DEPTH_W-1:0] db_tx_reg   [0:QB_W];
    logic signed [DEPTH_W-1:0] db_ty_reg   [0:QB_W];
    logic [31:0]               db_dist_reg [0:QB_W];

    // Check ranges: center must fit 16 bits, size 15 bits
    always_ff @(posedge aclk) begin
        if (en[ST_DB0]) begin
            db_remc_reg[0] <= s32_numc_reg;
            db_rems_reg[0] <= s32_nums_reg;
            db_qc_reg[0]   <= '0;
            db_qs_reg[0]   <= '0;
            db_den_reg[0]  <= s32_den_reg;
            db_ovfc_reg[0] <= CB_W'(s32_numc_reg) >= (CB_W'(s32_den_reg) << QB_W);
            db_ovfs_reg[0] <= CB_W'(s32_nums_reg) >= (CB_W'(s32_den_reg) << SIZE_W);
            db_negc_reg[0] <= s32_negc_reg;
            db_tx_reg[0]   <= s32_tx_reg;
            db_ty_reg[0]   <= s32_ty_reg;
            db_dist_reg[0] <= s32_dist_reg;
        end
    end

    generate
        for (g = 1; g <= QB_W; g++) begin : g_div_b
            localparam int BIT = QB_W - g;
            logic [CB_W-1:0] dshift;
            logic            takec, takes;
            logic [NB_W-1:0] remc_next;
            logic [NS_W-1:0] rems_next;
            logic [QB_W-1:0] qc_next, qs_next;

            assign dshift = CB_W'(db_den_reg[g-1]) << BIT;
            assign takec  = CB_W'(db_remc_reg[g-1]) >= dshift;
            assign takes  = CB_W'(db_rems_reg[g-1]) >= dshift;

            always_comb begin
                remc_next    = takec ? db_remc_reg[g-1] - NB_W'(dshift) : db_remc_reg[g-1];
                rems_next    = takes ? db_rems_reg[g-1] - NS_W'(dshift) : db_rems_reg[g-1];
                qc_next      = db_qc_reg[g-1];
                qs_next      = db_qs_reg[g-1];
                qc_next[BIT] = takec;
                qs_next[BIT] = takes;
            end

            always_ff @(posedge aclk) begin
                if (en[ST_DB0+g]) begin
                    db_remc_reg[g] <= remc_next;
                    db_rems_reg[g] <= rems_next;
                    db_qc_reg[g]   <= qc_next;
                    db_qs_reg[g]   <= qs_next;
                    db_den_reg[g]  <= db_den_reg[g-1];
                    db_ovfc_reg[g] <= db_ovfc_reg[g-1];
                    db_ovfs_reg[g] <= db_ovfs_reg[g-1];
                    db_negc_reg[g] <= db_negc_reg[g-1];
                    db_tx_reg[g]   <= db_tx_reg[g-1];
                    db_ty_reg[g]   <= db_ty_reg[g-1];
                    db_dist_reg[g] <= db_dist_reg[g-1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage: center column and size, zero depth handled here
    // ------------------------------------------------------------------
    logic                      tz;
    logic signed [COL_W-1:0]   s50_center_reg;
    logic [SIZE_W-1:0]         s50_size_reg;
    logic signed [DEPTH_W-1:0] s50_tx_reg, s50_ty_reg;
    logic [31:0]               s50_dist_reg;

    assign tz = (db_ty_reg[QB_W] == '0);

    always_ff @(posedge aclk) begin
        if (en[ST_CS]) begin
            s50_center_reg <= tz ? $signed(COL_W'(half_w)) :
                              sat_col(db_negc_reg[QB_W], db_ovfc_reg[QB_W], db_qc_reg[QB_W]);
            s50_size_reg   <= (tz || db_ovfs_reg[QB_W]) ? SIZE_MAX
                                                        : db_qs_reg[QB_W][SIZE_W-1:0];
            s50_tx_reg     <= db_tx_reg[QB_W];
            s50_ty_reg     <= db_ty_reg[QB_W];
            s50_dist_reg   <= db_dist_reg[QB_W];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: draw bounds
    // ------------------------------------------------------------------
    logic [SIZE_W-2:0]       hs;
    logic signed [14:0]      top_d;
    logic [14:0]             bot_sum;
    logic [SCREEN_W-1:0]     h_m1;
    logic [ROW_W-1:0]        top_next, bot_next;
    logic signed [COL_W:0]   left_d, right_sum, w_s, right_lim;
    logic [SIZE_W-1:0]       left_next;
    logic signed [COL_W-1:0] right_next;

    always_comb begin
        hs      = s50_size_reg[SIZE_W-1:1];
        // top clamps at zero
        top_d    = $signed({3'b0, half_h}) - $signed({1'b0, hs});
        top_next = top_d[14] ? '0 : top_d[ROW_W-1:0];
        // bottom clamps to height minus one, then to the row range
        bot_sum = 15'(hs) + 15'(half_h);
        h_m1    = screen_height_reg - 1'b1;
        if (bot_sum >= 15'(screen_height_reg)) begin
            if (screen_height_reg == '0) begin
                bot_next = '0;
            end else begin
                bot_next = (h_m1 > SCREEN_W'(ROW_MAX)) ? ROW_MAX : h_m1[ROW_W-1:0];
            end
        end else begin
            bot_next = (bot_sum > 15'(ROW_MAX)) ? ROW_MAX : bot_sum[ROW_W-1:0];
        end
        // left clamps at zero
        left_d    = (COL_W+1)'(s50_center_reg) - $signed({3'b0, hs});
        left_next = left_d[COL_W] ? '0 : left_d[SIZE_W-1:0];
        // right clamps to width minus one, then to the row range
        right_sum = (COL_W+1)'(s50_center_reg) + $signed({3'b0, hs});
        w_s       = $signed({4'b0, screen_width_reg});
        right_lim = (right_sum >= w_s) ? w_s - $signed((COL_W+1)'(1)) : right_sum;
        right_next = (right_lim > $signed((COL_W+1)'(ROW_MAX))) ?
                     $signed(COL_W'(ROW_MAX)) : right_lim[COL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            m_dist_sq     <= s50_dist_reg;
            m_cam_x       <= s50_tx_reg;
            m_cam_depth   <= s50_ty_reg;
            m_in_front    <= !s50_ty_reg[DEPTH_W-1] && (s50_ty_reg != '0);
            m_depth_zero  <= (s50_ty_reg == '0);
            m_center_col  <= s50_center_reg;
            m_sprite_size <= s50_size_reg;
            m_top_row     <= top_next;
            m_bottom_row  <= bot_next;
            m_left_col    <= left_next;
            m_right_col   <= right_next;
        end
    end

    assign m_valid = v_reg[ST_OUT];

endmodule

// ----- src/scp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for sprite_camera_projection, bound to the top level.
// Depends only on the top level's clock, reset and result channel ports.
module scp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [31:0]        m_dist_sq,
    input logic signed [23:0] m_cam_depth,
    input logic               m_in_front,
    input logic               m_depth_zero,
    input logic [14:0]        m_sprite_size
);

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cam_depth) && $stable(m_dist_sq))
        else $error("result changed while stalled");

    // Flags agree with depth
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_depth_zero == (m_cam_depth == 24'sd0)))
        else $error("depth_zero does not match depth");

    a_front: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_in_front == (m_cam_depth > 24'sd0)))
        else $error("in_front does not match depth");

    // Zero depth saturates the size
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_depth_zero |-> m_sprite_size == 15'h7fff)
        else $error("size not saturated at zero depth");

    // Drop results at reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sprite_camera_projection scp_checker u_scp_checker (.*);
